### rtl/wfc_pkg.sv
// ----------------------------------------------------------------------------
// Word frequency counter package
// Shared constants, types and a helper function for the word counter.
// ----------------------------------------------------------------------------
package wfc_pkg;

   localparam int Buckets   = 128;
   localparam int Ways      = 4;
   localparam int MaxWord   = 26;
   localparam int CountBits = 32;

   localparam int BucketBits = $clog2(Buckets);
   localparam int WayBits    = (Ways > 1) ? $clog2(Ways) : 1;
   localparam int EntryBits  = BucketBits + WayBits;
   localparam int Entries    = Buckets * Ways;
   localparam int CharBits   = (MaxWord > 1) ? $clog2(MaxWord) : 1;
   localparam int LenBits    = 6;
   localparam int QueueDepth = 4;
   localparam int QueueBits  = $clog2(QueueDepth);

   localparam logic [7:0] Delim = 8'd32;
   localparam logic [BucketBits-1:0] HashStart = BucketBits'(5381 % Buckets);

   localparam logic [1:0] StatusHit  = 2'd0;
   localparam logic [1:0] StatusNew  = 2'd1;
   localparam logic [1:0] StatusFull = 2'd2;
   localparam logic [1:0] StatusLong = 2'd3;

   typedef struct packed {
      logic [BucketBits-1:0] bucket;
      logic [LenBits-1:0]    length;
      logic                  over;
      logic                  last;
      logic [MaxWord*8-1:0]  chars;
   } word_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_READ, ST_CMP, ST_WRITE, ST_OUT
   } state_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'd65 && c <= 8'd90) r = c + 8'd32;
      return r;
   endfunction

endpackage

### rtl/wfc_front.sv
// ----------------------------------------------------------------------------
// Word frequency counter front end
// Collects bytes into words, hashes them and hands each word on.
// ----------------------------------------------------------------------------
module wfc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_end,
   output logic              word_valid,
   input  logic              word_ready,
   output wfc_pkg::word_type word_data
);

   logic [wfc_pkg::MaxWord*8-1:0]    chars_ff, chars_in;
   logic [wfc_pkg::LenBits-1:0]      len_ff, len_in;
   logic                             over_ff, over_in;
   logic [wfc_pkg::BucketBits-1:0]   hash_ff, hash_in;
   logic                             is_char, close, take;
   logic [wfc_pkg::LenBits-1:0]      new_len;
   logic [wfc_pkg::BucketBits+5:0]   prod;

   assign in_ready = word_ready;
   assign take     = in_valid && in_ready;
   assign is_char  = in_byte != wfc_pkg::Delim;
   assign new_len  = (is_char && len_ff != '1) ? len_ff + 1'b1 : len_ff;
   assign close    = (!is_char || in_end) && new_len != '0;
   assign prod     = {6'd0, hash_ff} * (wfc_pkg::BucketBits+6)'(33)
                     + (wfc_pkg::BucketBits+6)'(wfc_pkg::fold(in_byte));

   always_comb begin
      chars_in = chars_ff;
      over_in  = over_ff;
      hash_in  = hash_ff;
      if (is_char) begin
         if (32'(len_ff) < wfc_pkg::MaxWord) begin
            chars_in[len_ff*8 +: 8] = in_byte;
         end else begin
            over_in = 1'b1;
         end
         hash_in = prod[wfc_pkg::BucketBits-1:0];
      end
      len_in = new_len;
      word_data.bucket = hash_in;
      word_data.length = new_len;
      word_data.over   = over_in;
      word_data.last   = in_end;
      word_data.chars  = chars_in;
      if (close) begin
         len_in  = '0;
         over_in = 1'b0;
         hash_in = wfc_pkg::HashStart;
      end
   end

   assign word_valid = take && close;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         over_ff <= 1'b0;
         hash_ff <= wfc_pkg::HashStart;
      end else if (take) begin
         len_ff  <= len_in;
         over_ff <= over_in;
         hash_ff <= hash_in;
      end
      if (take) chars_ff <= chars_in;
   end

endmodule

### rtl/wfc_queue.sv
// ----------------------------------------------------------------------------
// Word frequency counter word queue
// Short FIFO that decouples word collection from the table search.
// ----------------------------------------------------------------------------
module wfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              not_full,
   input  wfc_pkg::word_type push_data,
   output logic              not_empty,
   input  logic              pop,
   output wfc_pkg::word_type pop_data
);

   wfc_pkg::word_type             mem_ff [wfc_pkg::QueueDepth];
   logic [wfc_pkg::QueueBits-1:0] wr_ff, rd_ff;
   logic [wfc_pkg::QueueBits:0]   cnt_ff;

   assign not_full  = cnt_ff != (wfc_pkg::QueueBits+1)'(wfc_pkg::QueueDepth);
   assign not_empty = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (wfc_pkg::QueueBits+1)'(push) - (wfc_pkg::QueueBits+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

### rtl/wfc_back.sv
// ----------------------------------------------------------------------------
// Word frequency counter table engine
// Clears the table after reset, then searches one bucket way by way for a word
// that is not overlong, updates a hit or fills a free way, and emits a result.
// ----------------------------------------------------------------------------
module wfc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            word_valid,
   output logic                            word_pop,
   input  wfc_pkg::word_type               word_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [47:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            busy
);

   logic [wfc_pkg::LenBits-1:0]   len_mem   [wfc_pkg::Entries];
   logic [wfc_pkg::MaxWord*8-1:0] chars_mem [wfc_pkg::Entries];
   logic [wfc_pkg::CountBits-1:0] count_mem [wfc_pkg::Entries];
   logic                          valid_mem [wfc_pkg::Entries];

   wfc_pkg::state_type            state_ff, state_in;
   logic [wfc_pkg::WayBits-1:0]   way_ff, way_in, free_ff, free_in;
   logic                          has_free_ff, has_free_in;
   logic [wfc_pkg::EntryBits-1:0] clr_ff, clr_in;
   logic [wfc_pkg::LenBits-1:0]   rd_len_ff;
   logic [wfc_pkg::MaxWord*8-1:0] rd_chars_ff;
   logic [wfc_pkg::CountBits-1:0] rd_count_ff;
   logic                          rd_valid_ff;
   logic [wfc_pkg::CountBits-1:0] cnt_ff, cnt_in;
   logic [1:0]                    status_ff, status_in;
   logic [wfc_pkg::EntryBits-1:0] addr;
   logic [wfc_pkg::EntryBits-1:0] waddr;
   logic [wfc_pkg::EntryBits-1:0] vaddr;
   logic                          match, we, vwe, vdata;
   logic [wfc_pkg::CountBits-1:0] wr_count;
   logic [31:0]                   out_count;

   assign addr  = {word_data.bucket, way_ff};
   assign waddr = {word_data.bucket,
                   (status_ff == wfc_pkg::StatusNew) ? free_ff : way_ff};

   always_comb begin
      match = word_data.length == rd_len_ff && rd_valid_ff;
      for (int i = 0; i < wfc_pkg::MaxWord; i++) begin
         if (i < 32'(word_data.length) &&
             wfc_pkg::fold(rd_chars_ff[i*8 +: 8]) != wfc_pkg::fold(word_data.chars[i*8 +: 8]))
            match = 1'b0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      way_in      = way_ff;
      free_in     = free_ff;
      has_free_in = has_free_ff;
      clr_in      = clr_ff;
      cnt_in      = cnt_ff;
      status_in   = status_ff;
      case (state_ff)
         wfc_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == wfc_pkg::Entries - 1) state_in = wfc_pkg::ST_IDLE;
         end
         wfc_pkg::ST_IDLE: begin
            if (word_valid) begin
               way_in      = '0;
               has_free_in = 1'b0;
               if (word_data.over) begin
                  status_in = wfc_pkg::StatusLong;
                  cnt_in    = '0;
                  state_in  = wfc_pkg::ST_OUT;
               end else begin
                  state_in = wfc_pkg::ST_READ;
               end
            end
         end
         wfc_pkg::ST_READ: state_in = wfc_pkg::ST_CMP;
         wfc_pkg::ST_CMP: begin
            if (match) begin
               cnt_in    = (rd_count_ff == '1) ? rd_count_ff : rd_count_ff + 1'b1;
               status_in = wfc_pkg::StatusHit;
               state_in  = wfc_pkg::ST_WRITE;
            end else begin
               if (!rd_valid_ff && !has_free_ff) begin
                  has_free_in = 1'b1;
                  free_in     = way_ff;
               end
               if (32'(way_ff) == wfc_pkg::Ways - 1) begin
                  if (!rd_valid_ff || has_free_ff) begin
                     cnt_in    = wfc_pkg::CountBits'(1);
                     status_in = wfc_pkg::StatusNew;
                     state_in  = wfc_pkg::ST_WRITE;
                  end else begin
                     cnt_in    = '0;
                     status_in = wfc_pkg::StatusFull;
                     state_in  = wfc_pkg::ST_OUT;
                  end
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = wfc_pkg::ST_READ;
               end
            end
         end
         wfc_pkg::ST_WRITE: state_in = wfc_pkg::ST_OUT;
         wfc_pkg::ST_OUT:   if (rsp_tready) state_in = wfc_pkg::ST_IDLE;
         default:           state_in = wfc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      we         = state_ff == wfc_pkg::ST_WRITE;
      vwe        = state_ff == wfc_pkg::ST_CLEAR || we;
      vaddr      = (state_ff == wfc_pkg::ST_CLEAR) ? clr_ff : waddr;
      vdata      = we;
      wr_count   = cnt_ff;
      word_pop   = state_ff == wfc_pkg::ST_OUT && rsp_tready;
      busy       = state_ff != wfc_pkg::ST_IDLE;
      out_count  = 32'(cnt_ff);
      rsp_tvalid = state_ff == wfc_pkg::ST_OUT;
      rsp_tdata  = {1'b0, word_data.length, status_ff, out_count, word_data.bucket};
      rsp_tlast  = word_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wfc_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      way_ff      <= way_in;
      free_ff     <= free_in;
      has_free_ff <= has_free_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      rd_len_ff   <= len_mem[addr];
      rd_chars_ff <= chars_mem[addr];
      rd_count_ff <= count_mem[addr];
      rd_valid_ff <= valid_mem[addr];
      if (vwe) valid_mem[vaddr] <= vdata;
      if (we) begin
         count_mem[waddr] <= wr_count;
         if (status_ff == wfc_pkg::StatusNew) begin
            len_mem[waddr]   <= word_data.length;
            chars_mem[waddr] <= word_data.chars;
         end
      end
   end

endmodule

### rtl/word_frequency_counter_core.sv
// ----------------------------------------------------------------------------
// Word frequency counter core
// Counts case-insensitive words in a byte stream with a hashed table.
// ----------------------------------------------------------------------------
// Each byte is taken in one cycle while the four-word queue has room.
// The table engine passes through an idle state, a read and a compare state
// for each way searched, a write state and the output state; a full bucket
// skips the write, an overlong word skips to output, and output may stall.
// Synchronous reset clears the pending word and the queue, then a clearing
// pass over every entry empties the table before the first word is searched.
module word_frequency_counter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // bucket, word_count, status, word_length
   output logic        rsp_tlast    // last
);

   logic              fw_valid, fw_ready, q_ne, q_pop, busy;
   wfc_pkg::word_type fw_data, q_data;

   wfc_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata), .in_end(req_tlast),
      .word_valid(fw_valid), .word_ready(fw_ready), .word_data(fw_data)
   );

   wfc_queue u_queue (
      .clock, .reset,
      .push(fw_valid), .not_full(fw_ready), .push_data(fw_data),
      .not_empty(q_ne), .pop(q_pop), .pop_data(q_data)
   );

   wfc_back u_back (
      .clock, .reset,
      .word_valid(q_ne), .word_pop(q_pop), .word_data(q_data),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .busy
   );

   a_pop_out: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> rsp_tvalid && rsp_tready) else $error("pop without output");
   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> busy && q_ne) else $error("output without word");
   a_zero_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[40:39] == wfc_pkg::StatusLong |-> rsp_tdata[38:7] == '0)
      else $error("dropped word has count");

endmodule

### sim/word_frequency_counter_core_tb.sv
// ----------------------------------------------------------------------------
// Word frequency counter core testbench
// Streams text bytes into the core and keeps its own model of the word table.
// A short directed table is followed by random words, many of them built to
// share a few buckets so that ways fill up, with random gaps on both sides.
// Every result transfer is checked field by field against the model.
// ----------------------------------------------------------------------------
module word_frequency_counter_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [6:0]  bucket;
      logic [31:0] word_count;
      logic [1:0]  status;
      logic [5:0]  word_length;
      logic        last;
   } word_result_type;

   typedef struct {
      logic [7:0]  text_byte;
      logic        end_of_text;
      bit          typed;
      logic [1:0]  status;
      logic [31:0] word_count;
      logic [5:0]  word_length;
   } text_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   word_result_type expected_words[$];
   text_row_type    text_rows[$];
   int              mismatches = 0;
   bit              no_idle = 0;

   // Model of the pending word and of the table.
   logic [7:0]  pend_chars[wfc_pkg::MaxWord];
   int          pend_len;
   bit          pend_over;
   logic [63:0] pend_hash;
   bit          tab_valid[wfc_pkg::Entries];
   int          tab_len[wfc_pkg::Entries];
   logic [7:0]  tab_chars[wfc_pkg::Entries][wfc_pkg::MaxWord];
   logic [31:0] tab_count[wfc_pkg::Entries];

   // Words used by the random part.
   logic [7:0]  pool_chars[64][wfc_pkg::MaxWord];
   int          pool_len[64];
   int          pool_size = 0;

   word_frequency_counter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] lower_case(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   function automatic bit count_word(input logic [7:0] b, input logic eot,
                                     output word_result_type r);
      int base;
      int e;
      bit hit;
      r = '{default: '0};
      if (b != wfc_pkg::Delim) begin
         if (pend_len < wfc_pkg::MaxWord) pend_chars[pend_len] = b;
         else pend_over = 1;
         pend_hash = pend_hash * 64'd33 + 64'(lower_case(b));
         if (pend_len < 63) pend_len++;
      end
      if (!((b == wfc_pkg::Delim || eot) && pend_len > 0)) return 0;
      r.bucket      = pend_hash[6:0];
      r.word_length = 6'(pend_len);
      r.last        = eot;
      base          = int'(pend_hash[6:0]) * wfc_pkg::Ways;
      if (pend_over) begin
         r.status = wfc_pkg::StatusLong;
      end else begin
         r.status = wfc_pkg::StatusFull;
         for (int w = 0; w < wfc_pkg::Ways && r.status == wfc_pkg::StatusFull; w++) begin
            e = base + w;
            if (tab_valid[e] && tab_len[e] == pend_len) begin
               hit = 1;
               for (int i = 0; i < pend_len; i++)
                  if (lower_case(tab_chars[e][i]) != lower_case(pend_chars[i])) hit = 0;
               if (hit) begin
                  if (tab_count[e] != '1) tab_count[e]++;
                  r.word_count = tab_count[e];
                  r.status     = wfc_pkg::StatusHit;
               end
            end
         end
         for (int w = 0; w < wfc_pkg::Ways && r.status == wfc_pkg::StatusFull; w++) begin
            e = base + w;
            if (!tab_valid[e]) begin
               tab_valid[e] = 1;
               tab_len[e]   = pend_len;
               for (int i = 0; i < pend_len; i++) tab_chars[e][i] = pend_chars[i];
               tab_count[e] = 32'd1;
               r.word_count = 32'd1;
               r.status     = wfc_pkg::StatusNew;
            end
         end
      end
      pend_len  = 0;
      pend_over = 0;
      pend_hash = 64'd5381;
      return 1;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eot, input bit typed,
                            input logic [1:0] st, input logic [31:0] cnt,
                            input logic [5:0] len);
      int gap;
      word_result_type r;
      gap = 0;
      if (!no_idle && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      if (count_word(b, eot, r)) begin
         if (typed) begin
            if (r.status != st) begin
               $error("status: expected %0d, actual %0d", st, r.status);
               mismatches++;
            end
            if (r.word_count != cnt) begin
               $error("word_count: expected %0d, actual %0d", cnt, r.word_count);
               mismatches++;
            end
            if (r.word_length != len) begin
               $error("word_length: expected %0d, actual %0d", len, r.word_length);
               mismatches++;
            end
            r.status      = st;
            r.word_count  = cnt;
            r.word_length = len;
         end
         expected_words = {expected_words, r};
      end
      @(negedge clock);
   endtask

   task automatic add_row(input logic [7:0] b, input logic eot, input bit typed,
                          input logic [1:0] st, input logic [31:0] cnt,
                          input logic [5:0] len);
      text_row_type row;
      row = '{b, eot, typed, st, cnt, len};
      text_rows = {text_rows, row};
   endtask

   function automatic logic [6:0] pool_bucket(input int k);
      logic [63:0] h;
      h = 64'd5381;
      for (int i = 0; i < pool_len[k]; i++) h = h * 64'd33 + 64'(lower_case(pool_chars[k][i]));
      return h[6:0];
   endfunction

   task automatic send_word(input int k, input bit fresh_long);
      int n;
      logic [7:0] c;
      bit eot_on_last;
      n = fresh_long ? $urandom_range(27, 70) : pool_len[k];
      eot_on_last = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
         if (fresh_long) begin
            c = 8'($urandom_range(0, 255));
            if (c == wfc_pkg::Delim) c = 8'd65;
         end else begin
            c = pool_chars[k][i];
         end
         if (((c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90)) && $urandom_range(0, 1))
            c = c ^ 8'd32;
         send_byte(c, eot_on_last && i == n - 1, 1'b0, 2'd0, 32'd0, 6'd0);
      end
      if (!eot_on_last) begin
         send_byte(wfc_pkg::Delim, $urandom_range(0, 15) == 0, 1'b0, 2'd0, 32'd0, 6'd0);
         while ($urandom_range(0, 5) == 0)
            send_byte(wfc_pkg::Delim, $urandom_range(0, 3) == 0, 1'b0, 2'd0, 32'd0, 6'd0);
      end
   endtask

   // Result side: random back-pressure.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0 && !no_idle) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = 0;
            if ($urandom_range(0, 3) == 0)
               stall = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      word_result_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result transfer: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            x = expected_words.pop_front();
            if (rsp_tdata[6:0] !== x.bucket) begin
               $error("bucket: expected %0d, actual %0d", x.bucket, rsp_tdata[6:0]);
               mismatches++;
            end
            if (rsp_tdata[38:7] !== x.word_count) begin
               $error("word_count: expected %0d, actual %0d", x.word_count, rsp_tdata[38:7]);
               mismatches++;
            end
            if (rsp_tdata[40:39] !== x.status) begin
               $error("status: expected %0d, actual %0d", x.status, rsp_tdata[40:39]);
               mismatches++;
            end
            if (rsp_tdata[46:41] !== x.word_length) begin
               $error("word_length: expected %0d, actual %0d", x.word_length,
                      rsp_tdata[46:41]);
               mismatches++;
            end
            if (rsp_tlast !== x.last) begin
               $error("last: expected %0d, actual %0d", x.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int k;
      int target;
      int waited;
      int sent;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      req_tlast  = 1'b0;
      pend_len   = 0;
      pend_over  = 0;
      pend_hash  = 64'd5381;
      for (int e = 0; e < wfc_pkg::Entries; e++) tab_valid[e] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: case folding, empty words, extreme bytes, overlong word.
      add_row(8'd97, 1'b0, 1'b0, 2'd0, 32'd0, 6'd0);
      add_row(wfc_pkg::Delim, 1'b0, 1'b1, wfc_pkg::StatusNew, 32'd1, 6'd1);
      add_row(8'd65, 1'b1, 1'b1, wfc_pkg::StatusHit, 32'd2, 6'd1);
      add_row(wfc_pkg::Delim, 1'b0, 1'b0, 2'd0, 32'd0, 6'd0);
      add_row(wfc_pkg::Delim, 1'b1, 1'b0, 2'd0, 32'd0, 6'd0);
      add_row(8'd0, 1'b0, 1'b0, 2'd0, 32'd0, 6'd0);
      add_row(8'd255, 1'b0, 1'b0, 2'd0, 32'd0, 6'd0);
      add_row(wfc_pkg::Delim, 1'b0, 1'b1, wfc_pkg::StatusNew, 32'd1, 6'd2);
      for (int i = 0; i < wfc_pkg::MaxWord; i++)
         add_row(8'd122 - 8'(i % 26), 1'b0, 1'b0, 2'd0, 32'd0, 6'd0);
      add_row(8'd90, 1'b1, 1'b1, wfc_pkg::StatusLong, 32'd0, 6'(wfc_pkg::MaxWord + 1));
      foreach (text_rows[i])
         send_byte(text_rows[i].text_byte, text_rows[i].end_of_text, text_rows[i].typed,
                   text_rows[i].status, text_rows[i].word_count, text_rows[i].word_length);

      // Words that collide in three buckets, so that ways fill up.
      for (int t = 0; t < 3; t++) begin
         target = $urandom_range(0, 127);
         for (int j = 0; j < 7; j++) begin
            do begin
               pool_len[pool_size] = $urandom_range(2, 4);
               for (int i = 0; i < pool_len[pool_size]; i++)
                  pool_chars[pool_size][i] = 8'($urandom_range(97, 122));
            end while (pool_bucket(pool_size) != 7'(target));
            pool_size++;
         end
      end
      // Other words: letters or arbitrary bytes, including full-length ones.
      while (pool_size < 64) begin
         pool_len[pool_size] = ($urandom_range(0, 7) == 0) ? wfc_pkg::MaxWord
                                                          : $urandom_range(1, 8);
         for (int i = 0; i < pool_len[pool_size]; i++) begin
            if ($urandom_range(0, 2) == 0) begin
               pool_chars[pool_size][i] = 8'($urandom_range(0, 255));
               if (pool_chars[pool_size][i] == wfc_pkg::Delim) pool_chars[pool_size][i] = 8'd95;
            end else begin
               pool_chars[pool_size][i] = 8'($urandom_range(97, 122));
            end
         end
         pool_size++;
      end

      sent = 0;
      while (sent < 800) begin
         if ($urandom_range(0, 24) == 0) no_idle = ~no_idle;
         k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) : $urandom_range(21, 63);
         send_word(k, $urandom_range(0, 19) == 0);
         sent += pool_len[k] + 2;
      end
      req_tvalid <= 1'b0;
      no_idle = 0;

      waited = 0;
      while (expected_words.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
